// ----- hdl/mcpmt_pkg.sv -----
`timescale 1ns / 1ps

package mcpmt_pkg;

   localparam int DEF_PORTS = 8;
   localparam int DEF_GPP   = 4;
   localparam int CSR_AW    = 3;

   localparam logic [CSR_AW-1:0] CSR_OWN_ADDR = 3'd0;

   localparam logic [2:0] ACT_CONNECT_CLIENT = 3'd0;
   localparam logic [2:0] ACT_CONNECT_ROUTER = 3'd1;
   localparam logic [2:0] ACT_DISCONNECT     = 3'd2;
   localparam logic [2:0] ACT_JOIN           = 3'd3;
   localparam logic [2:0] ACT_LEAVE          = 3'd4;
   localparam logic [2:0] ACT_SEND           = 3'd5;

   localparam logic [2:0] KIND_FORWARD      = 3'd0;
   localparam logic [2:0] KIND_DELIVER      = 3'd1;
   localparam logic [2:0] KIND_NOTIFY_JOIN  = 3'd2;
   localparam logic [2:0] KIND_NOTIFY_LEAVE = 3'd3;
   localparam logic [2:0] KIND_DONE         = 3'd4;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_BAD_PORT  = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  port_number;
      logic [31:0] peer_address;
      logic [15:0] group_id;
      logic [31:0] message_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  out_port;
      logic [15:0] group_id_out;
      logic [31:0] message_tag_out;
      logic [31:0] source_address;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_FIND,
      S_AFTER_FIND,
      S_NOTIFY_START,
      S_NOTIFY,
      S_LV_RD,
      S_LV_CHK,
      S_LV_SHIFT,
      S_LV_WR,
      S_SEND_START,
      S_SD_RD,
      S_SD_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load_item;
      logic       connect_write;
      logic       set_status;
      logic [1:0] status_val;
      logic       scan_clr;
      logic       p_clr;
      logic       p_inc;
      logic       set_found;
      logic       disconnect;
      logic       join_write;
      logic       mem_rd;
      logic       mem_rd_found;
      logic       rd_next;
      logic       slot_shift;
      logic       j_inc;
      logic       cnt_dec;
      logic       emit;
      logic [2:0] emit_kind;
   } cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       pnum_ok;
      logic       p_match;
      logic       p_last;
      logic       full_f;
      logic       j_lt_cnt_f;
      logic       jn_lt_cnt_f;
      logic       j_lt_cnt_p;
      logic       rd_match;
      logic       notify_ok;
      logic       send_skip;
      logic       p_router;
      logic       out_free;
   } sts_type;

endpackage

// ----- hdl/mcpmt_datapath.sv -----
`timescale 1ns / 1ps

module mcpmt_datapath import mcpmt_pkg::*; #(
   parameter int PORTS = DEF_PORTS,
   parameter int GPP   = DEF_GPP
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic [31:0] own_address,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int PW    = $clog2(PORTS);
   localparam int JW    = (GPP > 1) ? $clog2(GPP) : 1;
   localparam int CW    = $clog2(GPP + 1);
   localparam int AW    = PW + JW;
   localparam int DEPTH = 1 << AW;

   req_type        item_ff;
   logic [1:0]     status_ff;
   logic [PW-1:0]  p_ff, p_in;
   logic [PW-1:0]  found_ff;
   logic           found_valid_ff;
   logic [CW-1:0]  j_ff, j_in;
   logic [31:0]    addr_ff   [PORTS];
   logic           valid_ff  [PORTS];
   logic           router_ff [PORTS];
   logic [CW-1:0]  cnt_ff    [PORTS];
   logic [15:0]    slot_mem  [DEPTH];
   logic [15:0]    rd_data_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [PW-1:0]  conn_idx;
   logic [CW-1:0]  cnt_f, cnt_p;
   logic [JW-1:0]  rd_j;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [15:0]    wr_data;
   logic           wr_en;
   logic           out_free;
   logic           is_done;

   assign conn_idx = PW'(item_ff.port_number - 4'd1);
   assign cnt_f    = cnt_ff[found_ff];
   assign cnt_p    = cnt_ff[p_ff];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.action      = item_ff.action;
      sts.pnum_ok     = (item_ff.port_number != 4'd0)
                        && (6'(item_ff.port_number) <= 6'(PORTS));
      sts.p_match     = valid_ff[p_ff] && (addr_ff[p_ff] == item_ff.peer_address);
      sts.p_last      = (p_ff == PW'(PORTS - 1));
      sts.full_f      = (cnt_f == CW'(GPP));
      sts.j_lt_cnt_f  = (j_ff < cnt_f);
      sts.jn_lt_cnt_f = ((j_ff + CW'(1)) < cnt_f);
      sts.j_lt_cnt_p  = (j_ff < cnt_p);
      sts.rd_match    = (rd_data_ff == item_ff.group_id);
      sts.send_skip   = found_valid_ff && (p_ff == found_ff);
      sts.notify_ok   = !sts.send_skip && valid_ff[p_ff] && router_ff[p_ff];
      sts.p_router    = router_ff[p_ff];
      sts.out_free    = out_free;
   end

   // slot store: one write port, one registered read port
   assign rd_j    = cmd.rd_next ? JW'(j_ff + CW'(1)) : j_ff[JW-1:0];
   assign rd_addr = {(cmd.mem_rd_found ? found_ff : p_ff), rd_j};
   assign wr_en   = cmd.join_write || cmd.slot_shift;
   assign wr_addr = cmd.join_write ? {found_ff, cnt_f[JW-1:0]} : {found_ff, j_ff[JW-1:0]};
   assign wr_data = cmd.join_write ? item_ff.group_id : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.connect_write) begin
         addr_ff[conn_idx] <= item_ff.peer_address;
      end else if (cmd.disconnect) begin
         addr_ff[found_ff] <= 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORTS; i++) begin
            valid_ff[i]  <= 1'b0;
            router_ff[i] <= 1'b0;
            cnt_ff[i]    <= '0;
         end
      end else begin
         if (cmd.connect_write) begin
            valid_ff[conn_idx]  <= 1'b1;
            router_ff[conn_idx] <= (item_ff.action == ACT_CONNECT_ROUTER);
         end else if (cmd.disconnect) begin
            valid_ff[found_ff]  <= 1'b0;
            router_ff[found_ff] <= 1'b0;
            cnt_ff[found_ff]    <= '0;
         end else if (cmd.join_write) begin
            cnt_ff[found_ff] <= cnt_f + CW'(1);
         end else if (cmd.cnt_dec) begin
            cnt_ff[found_ff] <= cnt_f - CW'(1);
         end
      end
   end

   always_comb begin
      p_in = p_ff;
      j_in = j_ff;
      if (cmd.scan_clr || cmd.p_clr) begin
         p_in = '0;
         j_in = '0;
      end else if (cmd.p_inc) begin
         p_in = p_ff + PW'(1);
         j_in = '0;
      end else if (cmd.j_inc) begin
         j_in = j_ff + CW'(1);
      end
   end

   always_comb begin
      is_done               = (cmd.emit_kind == KIND_DONE);
      rsp_in.kind           = cmd.emit_kind;
      rsp_in.out_port       = is_done ? 3'd0 : 3'(p_ff);
      rsp_in.group_id_out   = is_done ? 16'd0 : item_ff.group_id;
      rsp_in.message_tag_out = (cmd.emit_kind == KIND_FORWARD
                                || cmd.emit_kind == KIND_DELIVER)
                               ? item_ff.message_tag : 32'd0;
      rsp_in.source_address = (cmd.emit_kind == KIND_FORWARD
                               || cmd.emit_kind == KIND_NOTIFY_JOIN
                               || cmd.emit_kind == KIND_NOTIFY_LEAVE)
                              ? own_address : 32'd0;
      rsp_in.status         = is_done ? status_ff : STAT_OK;
      rsp_in.last           = is_done;
      rsp_valid_in          = cmd.emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff      <= STAT_OK;
         p_ff           <= '0;
         j_ff           <= '0;
         found_ff       <= '0;
         found_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         p_ff         <= p_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.load_item) begin
            status_ff <= STAT_OK;
         end else if (cmd.set_status) begin
            status_ff <= cmd.status_val;
         end
         if (cmd.scan_clr) begin
            found_valid_ff <= 1'b0;
         end else if (cmd.set_found) begin
            found_ff       <= p_ff;
            found_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_join_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.join_write |-> !sts.full_f)
      else $error("join write into a full group list");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |=> (cnt_ff[found_ff] < CW'(GPP)))
      else $error("fill count out of range after leave");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result beat changed or dropped");

endmodule

// ----- hdl/mcpmt_ctrl.sv -----
`timescale 1ns / 1ps

module mcpmt_ctrl import mcpmt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (sts.action == ACT_DISCONNECT || sts.action == ACT_JOIN
                || sts.action == ACT_LEAVE || sts.action == ACT_SEND) begin
               state_in = S_FIND;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIND: begin
            if (sts.p_match) begin
               state_in = S_AFTER_FIND;
            end else if (sts.p_last) begin
               state_in = (sts.action == ACT_SEND) ? S_SEND_START : S_DONE;
            end
         end
         S_AFTER_FIND: begin
            priority if (sts.action == ACT_DISCONNECT) begin
               state_in = S_DONE;
            end else if (sts.action == ACT_JOIN) begin
               state_in = sts.full_f ? S_DONE : S_NOTIFY_START;
            end else if (sts.action == ACT_LEAVE) begin
               state_in = S_LV_RD;
            end else begin
               state_in = S_SEND_START;
            end
         end
         S_NOTIFY_START: state_in = S_NOTIFY;
         S_NOTIFY: begin
            if ((!sts.notify_ok || sts.out_free) && sts.p_last) state_in = S_DONE;
         end
         S_LV_RD:    state_in = sts.j_lt_cnt_f ? S_LV_CHK : S_NOTIFY_START;
         S_LV_CHK:   state_in = sts.rd_match ? S_LV_SHIFT : S_LV_RD;
         S_LV_SHIFT: state_in = sts.jn_lt_cnt_f ? S_LV_WR : S_NOTIFY_START;
         S_LV_WR:    state_in = S_LV_SHIFT;
         S_SEND_START: state_in = S_SD_RD;
         S_SD_RD: begin
            if (sts.send_skip || !sts.j_lt_cnt_p) begin
               if (sts.p_last) state_in = S_DONE;
            end else begin
               state_in = S_SD_CHK;
            end
         end
         S_SD_CHK: begin
            if (!sts.rd_match) begin
               state_in = S_SD_RD;
            end else if (sts.out_free) begin
               state_in = sts.p_last ? S_DONE : S_SD_RD;
            end
         end
         S_DONE: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         S_DISPATCH: begin
            cmd.scan_clr = 1'b1;
            if (sts.action == ACT_CONNECT_CLIENT || sts.action == ACT_CONNECT_ROUTER) begin
               if (sts.pnum_ok) begin
                  cmd.connect_write = 1'b1;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = STAT_BAD_PORT;
               end
            end
         end
         S_FIND: begin
            if (sts.p_match) begin
               cmd.set_found = 1'b1;
            end else if (sts.p_last) begin
               if (sts.action != ACT_SEND) begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = STAT_NOT_FOUND;
               end
            end else begin
               cmd.p_inc = 1'b1;
            end
         end
         S_AFTER_FIND: begin
            if (sts.action == ACT_DISCONNECT) begin
               cmd.disconnect = 1'b1;
            end else if (sts.action == ACT_JOIN) begin
               if (sts.full_f) begin
                  cmd.set_status = 1'b1;
                  cmd.status_val = STAT_FULL;
               end else begin
                  cmd.join_write = 1'b1;
               end
            end else if (sts.action == ACT_LEAVE) begin
               cmd.p_clr = 1'b1;
            end
         end
         S_NOTIFY_START: cmd.p_clr = 1'b1;
         S_NOTIFY: begin
            cmd.emit_kind = (sts.action == ACT_LEAVE) ? KIND_NOTIFY_LEAVE : KIND_NOTIFY_JOIN;
            if (!sts.notify_ok || sts.out_free) begin
               cmd.emit  = sts.notify_ok;
               cmd.p_inc = !sts.p_last;
            end
         end
         S_LV_RD: begin
            cmd.mem_rd       = sts.j_lt_cnt_f;
            cmd.mem_rd_found = 1'b1;
         end
         S_LV_CHK: cmd.j_inc = !sts.rd_match;
         S_LV_SHIFT: begin
            if (sts.jn_lt_cnt_f) begin
               cmd.mem_rd       = 1'b1;
               cmd.mem_rd_found = 1'b1;
               cmd.rd_next      = 1'b1;
            end else begin
               cmd.cnt_dec = 1'b1;
            end
         end
         S_LV_WR: begin
            cmd.slot_shift = 1'b1;
            cmd.j_inc      = 1'b1;
         end
         S_SEND_START: cmd.p_clr = 1'b1;
         S_SD_RD: begin
            if (sts.send_skip || !sts.j_lt_cnt_p) begin
               cmd.p_inc = !sts.p_last;
            end else begin
               cmd.mem_rd = 1'b1;
            end
         end
         S_SD_CHK: begin
            cmd.emit_kind = sts.p_router ? KIND_FORWARD : KIND_DELIVER;
            if (!sts.rd_match) begin
               cmd.j_inc = 1'b1;
            end else if (sts.out_free) begin
               cmd.emit  = 1'b1;
               cmd.p_inc = !sts.p_last;
            end
         end
         S_DONE: begin
            cmd.emit_kind = KIND_DONE;
            cmd.emit      = sts.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted beat not dispatched");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result emitted into an occupied output register");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && sts.out_free) |=> (state_ff == S_IDLE))
      else $error("done beat issued without return to idle");

endmodule

// ----- hdl/multicast_port_membership_table.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    req_type  (action, port, peer, group, tag)
// rsp       out        rsp_valid/ready    rsp_type  (results, done beat has last)
// csr       in/out     APB, pready = 1    own_address at byte address 0
//
// One item at a time. Connect and the unused actions go from dispatch straight to
// the done beat; disconnect, join and leave scan ports one per cycle (up to PORTS),
// leave then walks its group slots with a read and a check per slot, and
// notifications take one start state and then one port per cycle while the output
// is free. Send's length is set by the single-port slot store being read one slot
// at a time plus one end check per port. Reset is synchronous; fill counts stand in
// for slot valid bits, so no clearing pass follows reset. A stalled rsp beat holds
// the sequencer in place; the next item is taken once the done beat sits in the
// output register.

module multicast_port_membership_table import mcpmt_pkg::*; #(
   parameter int PORTS           = DEF_PORTS,
   parameter int GROUPS_PER_PORT = DEF_GPP
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] own_addr_ff;

   // configuration register: written on the access phase of an APB write
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_OWN_ADDR) ? own_addr_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= 32'd0;
      end else if (psel && penable && pwrite && (paddr == CSR_OWN_ADDR)) begin
         own_addr_ff <= pwdata;
      end
   end

   // sequencer: walks ports and slots, issues one command word per cycle
   mcpmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // port table, slot store, scan counters and output register
   mcpmt_datapath #(
      .PORTS (PORTS),
      .GPP   (GROUPS_PER_PORT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .own_address (own_addr_ff),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import mcpmt_pkg::*;

   localparam int NPORT = DEF_PORTS;
   localparam int NGRP  = DEF_GPP;

   // Expected-result store and membership predictor
   class membership_board;
      rsp_type     pending[$];
      logic [31:0] own_addr;
      logic [31:0] addr[NPORT];
      bit          used[NPORT];
      bit          router[NPORT];
      logic [15:0] grp[NPORT][NGRP];
      int          cnt[NPORT];
      int          errors;
      int          seen;

      function void clear();
         own_addr = '0;
         errors = 0;
         seen = 0;
         pending.delete();
         for (int i = 0; i < NPORT; i++) begin
            addr[i] = '0;
            used[i] = 0;
            router[i] = 0;
            cnt[i] = 0;
         end
      endfunction

      function int lookup(logic [31:0] a);
         for (int i = 0; i < NPORT; i++)
            if (used[i] && addr[i] == a) return i;
         return -1;
      endfunction

      function void push(logic [2:0] k, int p, logic [15:0] g, logic [31:0] t,
                         logic [31:0] s, logic [1:0] st, logic l);
         rsp_type r;
         r.kind = k;
         r.out_port = p[2:0];
         r.group_id_out = g;
         r.message_tag_out = t;
         r.source_address = s;
         r.status = st;
         r.last = l;
         pending = {pending, r};
      endfunction

      function void tell_routers(logic [2:0] k, int except, logic [15:0] g);
         for (int i = 0; i < NPORT; i++)
            if (i != except && used[i] && router[i]) push(k, i, g, '0, own_addr, STAT_OK, 0);
      endfunction

      // note an accepted input beat and queue its results
      function void note_request(req_type q);
         logic [1:0] st;
         int p, j;
         st = STAT_OK;
         case (q.action)
            ACT_CONNECT_CLIENT, ACT_CONNECT_ROUTER: begin
               if (q.port_number < 1 || q.port_number > NPORT) st = STAT_BAD_PORT;
               else begin
                  p = q.port_number - 1;
                  addr[p] = q.peer_address;
                  used[p] = 1;
                  router[p] = (q.action == ACT_CONNECT_ROUTER);
               end
            end
            ACT_DISCONNECT: begin
               p = lookup(q.peer_address);
               if (p < 0) st = STAT_NOT_FOUND;
               else begin
                  addr[p] = '0;
                  used[p] = 0;
                  router[p] = 0;
                  cnt[p] = 0;
               end
            end
            ACT_JOIN: begin
               p = lookup(q.peer_address);
               if (p < 0) st = STAT_NOT_FOUND;
               else if (cnt[p] >= NGRP) st = STAT_FULL;
               else begin
                  grp[p][cnt[p]] = q.group_id;
                  cnt[p]++;
                  tell_routers(KIND_NOTIFY_JOIN, p, q.group_id);
               end
            end
            ACT_LEAVE: begin
               p = lookup(q.peer_address);
               if (p < 0) st = STAT_NOT_FOUND;
               else begin
                  for (j = 0; j < cnt[p]; j++)
                     if (grp[p][j] == q.group_id) break;
                  if (j < cnt[p]) begin
                     for (; j + 1 < cnt[p]; j++) grp[p][j] = grp[p][j+1];
                     cnt[p]--;
                  end
                  tell_routers(KIND_NOTIFY_LEAVE, p, q.group_id);
               end
            end
            ACT_SEND: begin
               p = lookup(q.peer_address);
               for (int i = 0; i < NPORT; i++) begin
                  if (i == p) continue;
                  for (j = 0; j < cnt[i]; j++)
                     if (grp[i][j] == q.group_id) begin
                        if (router[i])
                           push(KIND_FORWARD, i, q.group_id, q.message_tag, own_addr, STAT_OK, 0);
                        else
                           push(KIND_DELIVER, i, q.group_id, q.message_tag, '0, STAT_OK, 0);
                        break;
                     end
               end
            end
            default: ;
         endcase
         push(KIND_DONE, 0, '0, '0, '0, st, 1);
      endfunction

      // compare one accepted result beat with the oldest expectation
      function void check_result(rsp_type r);
         rsp_type e;
         seen++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, r);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (r.kind !== e.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, e.kind, r.kind); errors++;
         end
         if (r.out_port !== e.out_port) begin
            $display("%0t: out_port exp %0d got %0d", $time, e.out_port, r.out_port); errors++;
         end
         if (r.group_id_out !== e.group_id_out) begin
            $display("%0t: group exp %h got %h", $time, e.group_id_out, r.group_id_out);
            errors++;
         end
         if (r.message_tag_out !== e.message_tag_out) begin
            $display("%0t: tag exp %h got %h", $time, e.message_tag_out, r.message_tag_out);
            errors++;
         end
         if (r.source_address !== e.source_address) begin
            $display("%0t: source exp %h got %h", $time, e.source_address, r.source_address);
            errors++;
         end
         if (r.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, r.status); errors++;
         end
         if (r.last !== e.last) begin
            $display("%0t: last exp %0d got %0d", $time, e.last, r.last); errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   rsp_type           rsp_data;
   logic              psel = 0, penable = 0, pwrite = 0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   membership_board board = new();
   int  sent_items;
   bit  hold_off;       // long receiver stall requested by the stimulus
   bit  stim_done;

   // small pool of addresses so that joins, leaves and sends hit live ports
   logic [31:0] peer_pool[8];

   multicast_port_membership_table DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Sample beats on the edge; predictor sees inputs in acceptance order.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) board.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // Receiver: stall on its own pattern, with quiet stretches and one long hold-off
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 40)) begin
            @(posedge clock);
            if (hold_off) begin
               rsp_ready <= 0;
               repeat (300) @(posedge clock);
               hold_off = 0;
            end
            case (mode)
               0: rsp_ready <= 1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ($urandom_range(0, 5) != 0);
            endcase
         end
      end
   end

   // Offer one item and hold it until the beat is taken
   task automatic put_item(input req_type q);
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   task automatic rest();
      req_valid <= 0;
      @(posedge clock);
   endtask

   // Burst of items with random gaps between bursts
   task automatic send_burst(input req_type q);
      put_item(q);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) rest();
   endtask

   task automatic apb_write(input logic [CSR_AW-1:0] a, input logic [31:0] d);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= d;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      board.own_addr = d;
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
   endtask

   // Drain every expectation, then allow for the block's tail latency
   task automatic settle();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic req_type make_item(logic [2:0] act, logic [3:0] pn, logic [31:0] pa,
                                         logic [15:0] g, logic [31:0] t);
      req_type q;
      q.action = act; q.port_number = pn; q.peer_address = pa;
      q.group_id = g; q.message_tag = t;
      return q;
   endfunction

   // Random item: mostly well-formed traffic on known peers, some noise
   function automatic req_type pick_item();
      req_type q;
      int r;
      q.message_tag = $urandom();
      q.group_id = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 5));
      q.group_id[15] = ($urandom_range(0, 7) == 0) ? ~q.group_id[15] : q.group_id[15];
      q.peer_address = ($urandom_range(0, 9) == 0) ? $urandom() : peer_pool[$urandom_range(0, 7)];
      q.port_number = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 8));
      r = $urandom_range(0, 99);
      if (r < 12)      q.action = ACT_CONNECT_CLIENT;
      else if (r < 22) q.action = ACT_CONNECT_ROUTER;
      else if (r < 28) q.action = ACT_DISCONNECT;
      else if (r < 55) q.action = ACT_JOIN;
      else if (r < 70) q.action = ACT_LEAVE;
      else if (r < 97) q.action = ACT_SEND;
      else             q.action = 3'($urandom_range(6, 7));
      return q;
   endfunction

   initial begin
      logic [31:0] own_values[4];
      board.clear();
      sent_items = 0;
      hold_off = 0;
      stim_done = 0;
      for (int i = 0; i < 8; i++) peer_pool[i] = $urandom();
      peer_pool[7] = 32'hFFFF_FFFF;
      own_values[0] = 32'h0; own_values[1] = 32'hFFFF_FFFF;
      own_values[2] = $urandom(); own_values[3] = 32'hA5A5_5A5A;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, every action, each named corner
      apb_write(CSR_OWN_ADDR, 32'hFFFF_FFFF);
      put_item(make_item(ACT_CONNECT_CLIENT, 4'd0, 32'h1, 16'h0, 32'h0));      // bad port low
      put_item(make_item(ACT_CONNECT_ROUTER, 4'd15, 32'h1, 16'h0, 32'h0));     // bad port high
      put_item(make_item(ACT_CONNECT_ROUTER, 4'd1, 32'h0, 16'h0, 32'h0));
      put_item(make_item(ACT_CONNECT_ROUTER, 4'd8, 32'hFFFF_FFFF, 16'h0, 32'h0));
      put_item(make_item(ACT_CONNECT_CLIENT, 4'd3, 32'h1234, 16'h0, 32'h0));
      put_item(make_item(ACT_CONNECT_CLIENT, 4'd4, 32'h1234, 16'h0, 32'h0));   // duplicate address
      for (int g = 0; g < 5; g++)                                               // last one overflows
         put_item(make_item(ACT_JOIN, 4'd0, 32'h1234, (g == 0) ? 16'hFFFF : 16'(g), 32'h0));
      put_item(make_item(ACT_JOIN, 4'd0, 32'hDEAD, 16'h7, 32'h0));             // unknown peer
      put_item(make_item(ACT_SEND, 4'd0, 32'h0, 16'hFFFF, 32'hFFFF_FFFF));
      put_item(make_item(ACT_SEND, 4'd0, 32'hBEEF, 16'h2, 32'h0));             // unknown sender
      put_item(make_item(ACT_LEAVE, 4'd0, 32'h1234, 16'h9, 32'h0));            // absent group
      put_item(make_item(ACT_LEAVE, 4'd0, 32'h1234, 16'hFFFF, 32'h0));
      put_item(make_item(ACT_LEAVE, 4'd0, 32'hDEAD, 16'h1, 32'h0));
      put_item(make_item(ACT_CONNECT_ROUTER, 4'd3, 32'h5678, 16'h0, 32'h0));   // reconnect keeps list
      put_item(make_item(ACT_SEND, 4'd0, 32'h0, 16'h2, 32'h1357_9BDF));
      put_item(make_item(ACT_DISCONNECT, 4'd0, 32'hDEAD, 16'h0, 32'h0));
      put_item(make_item(ACT_DISCONNECT, 4'd0, 32'h5678, 16'h0, 32'h0));
      put_item(make_item(3'd6, 4'd0, 32'h0, 16'h0, 32'h0));
      put_item(make_item(3'd7, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      settle();

      // Random phases across several own-address settings
      for (int ph = 0; ph < 4; ph++) begin
         apb_write(CSR_OWN_ADDR, own_values[ph]);
         // populate ports from the pool so traffic goes deep
         for (int i = 0; i < 8; i++)
            send_burst(make_item(($urandom_range(0, 1) == 1) ? ACT_CONNECT_ROUTER
                                 : ACT_CONNECT_CLIENT, 4'(i + 1), peer_pool[i], 16'h0, 32'h0));
         for (int k = 0; k < 80; k++) begin
            if (ph == 1 && k == 20) hold_off = 1;   // long receiver stall under load
            send_burst(pick_item());
         end
         settle();
      end
      stim_done = 1;

      $display("Covered %0d items and %0d result beats over 5 own-address settings,",
               sent_items, board.seen);
      $display("with bad ports, full lists, unknown peers, reconnects and a long stall.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

// ----- multicast_port_membership_table.f -----
hdl/mcpmt_pkg.sv
hdl/mcpmt_datapath.sv
hdl/mcpmt_ctrl.sv
hdl/multicast_port_membership_table.sv
tb/sv/tb.sv
